[hw/rtl/pte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pte_pkg: shared definitions of the permutation enumerator
// Types, codes and default constants for the transposition enumerator.
// ----------------------------------------------------------------------------
package pte_pkg;

    localparam int MAX_ITEMS_DEFAULT = 16;

    localparam int CFG_W  = 5;   // item_count register width
    localparam int IDX_W  = 4;   // read index width
    localparam int STAT_W = 2;   // status width
    localparam int POS_W  = 4;   // position and value width
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CFG_W-1:0] ITEM_COUNT_RESET = 5'd16;

    // word index of a register, taken from paddr[2]
    localparam logic REG_ITEM_COUNT = 1'b0;

    typedef enum logic [STAT_W-1:0] {
        ST_START   = 2'd0,
        ST_SWAP    = 2'd1,
        ST_EXHAUST = 2'd2,
        ST_READ    = 2'd3
    } t_status;

    typedef enum logic {
        KIND_ADVANCE = 1'b0,
        KIND_READ    = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_ANS,
        S_CNT_CHK,
        S_P_HI,
        S_P_LO,
        S_P_WHI,
        S_P_WLO
    } t_state;

    typedef struct packed {
        logic             rearm;
        logic [CFG_W-1:0] item_count;
    } t_cfg;

endpackage

[hw/rtl/pte_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pte_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pte_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/pte_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pte_ctrl: level-walk sequencer and swap datapath
// Walks the level counters one per cycle and swaps two store entries.
// ----------------------------------------------------------------------------
module pte_ctrl #(
    parameter int MAX_ITEMS = pte_pkg::MAX_ITEMS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pte_pkg::t_cfg              i_cfg,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic                       i_kind,
    input  logic [pte_pkg::IDX_W-1:0]  i_index,
    output logic                       o_done,
    output logic [pte_pkg::STAT_W-1:0] o_status,
    output logic [pte_pkg::POS_W-1:0]  o_first_pos,
    output logic [pte_pkg::POS_W-1:0]  o_second_pos,
    output logic [pte_pkg::POS_W-1:0]  o_value
);
    import pte_pkg::*;

    localparam int PAW  = $clog2(MAX_ITEMS);       // store address and data
    localparam int CAW  = $clog2(MAX_ITEMS + 1);   // level index
    localparam int NW   = (CAW > CFG_W) ? CAW : CFG_W;
    localparam int CDEP = MAX_ITEMS + 1;

    // sequencer state
    t_state           r_state, n_state;
    logic             r_started, n_started;
    logic [CAW-1:0]   r_k, n_k;
    logic [PAW-1:0]   r_hi, n_hi;
    logic [PAW-1:0]   r_lo, n_lo;
    logic [PAW-1:0]   r_tmp, n_tmp;
    logic             r_in_range, n_in_range;

    // result registers
    logic             r_done, n_done;
    t_status          r_status, n_status;
    logic [POS_W-1:0] r_first, n_first;
    logic [POS_W-1:0] r_second, n_second;
    logic [POS_W-1:0] r_value, n_value;

    // valid bits: an entry not written since re-arm reads as its reset value
    logic [MAX_ITEMS-1:0] r_pvld, n_pvld;
    logic [CDEP-1:0]      r_cvld, n_cvld;
    logic                 r_pv, r_cv;
    logic [PAW-1:0]       r_pa;

    // RAM ports
    logic           p_we, c_we;
    logic [PAW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
    logic [CAW-1:0] c_waddr, c_raddr;
    logic [PAW-1:0] c_wdata, c_rdata;

    // derived values
    logic [NW-1:0]        w_cnt_ext, w_max_ext;
    logic [CAW-1:0]       w_n;
    logic [PAW-1:0]       w_pval;
    logic [CAW-1:0]       w_c_cur, w_c_new, w_lo;
    logic [PAW+IDX_W-1:0] w_idx_ext;
    logic [PAW+POS_W-1:0] w_hi_ext, w_lo_ext, w_val_ext;
    logic                 w_idx_ok;

    pte_ram #(.WIDTH(PAW), .DEPTH(MAX_ITEMS)) u_perm (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    pte_ram #(.WIDTH(PAW), .DEPTH(CDEP)) u_cnt (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    // clamp the element count to the store depth
    assign w_cnt_ext = NW'(i_cfg.item_count);
    assign w_max_ext = NW'(MAX_ITEMS);
    assign w_n = (w_cnt_ext > w_max_ext) ? CAW'(w_max_ext) : CAW'(w_cnt_ext);

    assign w_pval  = r_pv ? p_rdata : r_pa;
    assign w_c_cur = r_cv ? CAW'(c_rdata) : '0;
    assign w_c_new = w_c_cur + CAW'(1);
    assign w_lo    = (!r_k[0] && (w_c_new > CAW'(2))) ? (r_k - CAW'(1) - w_c_new)
                                                      : (r_k - CAW'(2));

    assign w_idx_ext = {{PAW{1'b0}}, i_index};
    assign w_idx_ok  = ({28'd0, i_index} < 32'(MAX_ITEMS));
    assign w_hi_ext  = {{POS_W{1'b0}}, r_hi};
    assign w_lo_ext  = {{POS_W{1'b0}}, r_lo};
    assign w_val_ext = {{POS_W{1'b0}}, w_pval};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
            r_done    <= 1'b0;
            r_pvld    <= '0;
            r_cvld    <= '0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_done    <= n_done;
            r_pvld    <= n_pvld;
            r_cvld    <= n_cvld;
        end
        r_k        <= n_k;
        r_hi       <= n_hi;
        r_lo       <= n_lo;
        r_tmp      <= n_tmp;
        r_in_range <= n_in_range;
        r_status   <= n_status;
        r_first    <= n_first;
        r_second   <= n_second;
        r_value    <= n_value;
        r_pv       <= r_pvld[p_raddr];
        r_pa       <= p_raddr;
        r_cv       <= r_cvld[c_raddr];
    end

    always_comb begin
        n_state    = r_state;
        n_started  = r_started;
        n_k        = r_k;
        n_hi       = r_hi;
        n_lo       = r_lo;
        n_tmp      = r_tmp;
        n_in_range = r_in_range;
        n_done     = 1'b0;
        n_status   = r_status;
        n_first    = '0;
        n_second   = '0;
        n_value    = '0;
        n_pvld     = r_pvld;
        n_cvld     = r_cvld;
        p_we       = 1'b0;
        p_waddr    = r_hi;
        p_wdata    = w_pval;
        p_raddr    = r_hi;
        c_we       = 1'b0;
        c_waddr    = r_k;
        c_wdata    = '0;
        c_raddr    = r_k + CAW'(1);

        unique case (r_state)
            S_IDLE: begin
                p_raddr    = w_idx_ext[PAW-1:0];
                c_raddr    = CAW'(2);
                n_in_range = w_idx_ok;
                n_k        = CAW'(2);
                if (i_start) begin
                    if (i_kind == KIND_READ) begin
                        n_state = S_RD_ANS;
                    end else if (!r_started) begin
                        // restore identity and clear every counter
                        n_pvld    = '0;
                        n_cvld    = '0;
                        n_started = 1'b1;
                        n_done    = 1'b1;
                        n_status  = ST_START;
                    end else if (w_n < CAW'(2)) begin
                        n_started = 1'b0;
                        n_done    = 1'b1;
                        n_status  = ST_EXHAUST;
                    end else begin
                        n_state = S_CNT_CHK;
                    end
                end
            end
            S_RD_ANS: begin
                n_done   = 1'b1;
                n_status = ST_READ;
                n_value  = r_in_range ? w_val_ext[POS_W-1:0] : '0;
                n_state  = S_IDLE;
            end
            S_CNT_CHK: begin
                c_we         = 1'b1;
                n_cvld[r_k]  = 1'b1;
                if (w_c_cur == r_k - CAW'(1)) begin
                    // level full: clear it and move up
                    c_wdata = '0;
                    n_k     = r_k + CAW'(1);
                    if (r_k == w_n) begin
                        n_started = 1'b0;
                        n_done    = 1'b1;
                        n_status  = ST_EXHAUST;
                        n_state   = S_IDLE;
                    end
                end else begin
                    c_wdata = PAW'(w_c_new);
                    n_hi    = PAW'(r_k - CAW'(1));
                    n_lo    = PAW'(w_lo);
                    n_state = S_P_HI;
                end
            end
            S_P_HI: begin
                p_raddr = r_hi;
                n_state = S_P_LO;
            end
            S_P_LO: begin
                p_raddr = r_lo;
                n_tmp   = w_pval;
                n_state = S_P_WHI;
            end
            S_P_WHI: begin
                p_we         = 1'b1;
                p_waddr      = r_hi;
                p_wdata      = w_pval;
                n_pvld[r_hi] = 1'b1;
                n_state      = S_P_WLO;
            end
            S_P_WLO: begin
                p_we         = 1'b1;
                p_waddr      = r_lo;
                p_wdata      = r_tmp;
                n_pvld[r_lo] = 1'b1;
                n_done       = 1'b1;
                n_status     = ST_SWAP;
                n_first      = w_hi_ext[POS_W-1:0];
                n_second     = w_lo_ext[POS_W-1:0];
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a count write re-arms at identity
        if (i_cfg.rearm) begin
            n_pvld    = '0;
            n_cvld    = '0;
            n_started = 1'b0;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_first_pos  = r_first;
    assign o_second_pos = r_second;
    assign o_value      = r_value;

endmodule

[hw/rtl/permutation_transposition_enumerator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_transposition_enumerator_core: top level
// Steps through all permutations of item_count elements, one swap apart.
// ----------------------------------------------------------------------------
// Usage:
//   Commands transfer on start while busy is low. kind 0 advances the
//   permutation, kind 1 reads the element at index. Every command yields
//   exactly one result, shown on o_status and the position/value ports for
//   one cycle while o_done is high; the receiver always takes it.
//   A read answers from the store read port. The first advance loads the
//   identity. Any later advance walks the level counters and ends in a
//   swap, or in exhaustion once every level is full.
//   The walk checks one level counter per cycle through the counter RAM
//   read port; a swap then reads both entries and writes both back on the
//   single store port pair.
//   The APB port holds item_count at byte address 0; writing it re-arms the
//   sequence at identity. Reset also re-arms with item_count = 16. Both
//   clear valid bits at once: no clearing pass is needed.
// ----------------------------------------------------------------------------
module permutation_transposition_enumerator_core #(
    parameter int MAX_ITEMS = pte_pkg::MAX_ITEMS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // command channel
    input  logic                       start,
    output logic                       busy,
    input  logic [0:0]                 i_kind,
    input  logic [pte_pkg::IDX_W-1:0]  i_index,
    // result channel
    output logic                       o_done,
    output logic [pte_pkg::STAT_W-1:0] o_status,
    output logic [pte_pkg::POS_W-1:0]  o_first_pos,
    output logic [pte_pkg::POS_W-1:0]  o_second_pos,
    output logic [pte_pkg::POS_W-1:0]  o_value,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pte_pkg::APB_AW-1:0] paddr,
    input  logic [pte_pkg::APB_DW-1:0] pwdata,
    output logic [pte_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import pte_pkg::*;

    logic [CFG_W-1:0] r_item_count;
    logic             w_wr;
    logic             w_sel_count;
    t_cfg             w_cfg;

    // decode the word address; other words read as zero and drop writes
    assign w_sel_count = (paddr[2] == REG_ITEM_COUNT);
    assign w_wr        = psel && penable && pwrite && w_sel_count;
    assign pready      = 1'b1;
    assign prdata      = w_sel_count ? {{(APB_DW-CFG_W){1'b0}}, r_item_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= ITEM_COUNT_RESET;
        end else if (w_wr) begin
            r_item_count <= pwdata[CFG_W-1:0];
        end
    end

    // hand the count and a re-arm pulse to the sequencer
    assign w_cfg.rearm      = w_wr;
    assign w_cfg.item_count = r_item_count;

    pte_ctrl #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_start      (start),
        .o_busy       (busy),
        .i_kind       (i_kind[0]),
        .i_index      (i_index),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_first_pos  (o_first_pos),
        .o_second_pos (o_second_pos),
        .o_value      (o_value)
    );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the transposition enumerator
// Drives advance and read commands at random spacing, rewrites item_count
// over APB between phases, and checks each result transfer against an
// in-bench model of the swap sequence.
// ----------------------------------------------------------------------------
module testbench;

    import pte_pkg::*;

    localparam int PERM_SLOTS = MAX_ITEMS_DEFAULT;
    localparam int ITEM_GOAL  = 1050;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 30;

    localparam logic [APB_AW-1:0] ADDR_ITEM_COUNT = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_UNMAPPED   = 3'd4;

    typedef struct {
        t_kind            kind;
        logic [IDX_W-1:0] index;
    } t_cmd;

    typedef struct {
        t_status          status;
        logic [POS_W-1:0] first_pos;
        logic [POS_W-1:0] second_pos;
        logic [POS_W-1:0] value;
    } t_answer;

    // clock, reset and DUT ports; every input starts at a known value
    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                start    = 1'b0;
    logic                busy;
    logic [0:0]          i_kind   = 1'b0;
    logic [IDX_W-1:0]    i_index  = '0;
    logic                o_done;
    logic [STAT_W-1:0]   o_status;
    logic [POS_W-1:0]    o_first_pos;
    logic [POS_W-1:0]    o_second_pos;
    logic [POS_W-1:0]    o_value;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    t_cmd    cmd_backlog[$];
    t_answer pending_answers[$];
    int      err_cnt   = 0;
    int      cycle_cnt = 0;
    bit      rst_done  = 1'b0;
    bit      cmd_taken = 1'b0;
    bit      no_gap    = 1'b0;

    // model state of the enumerator
    logic [POS_W-1:0] perm_img  [PERM_SLOTS];
    logic [POS_W-1:0] level_cnt [PERM_SLOTS+1];
    bit               seq_started;
    logic [CFG_W-1:0] count_reg;

    permutation_transposition_enumerator_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_index      (i_index),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_first_pos  (o_first_pos),
        .o_second_pos (o_second_pos),
        .o_value      (o_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("[permutation_transposition_enumerator_core] ERROR");
            $finish;
        end
    end

    task automatic note_mismatch(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Model of the swap sequence
    // ------------------------------------------------------------------
    function automatic void rearm_perm();
        for (int i = 0; i < PERM_SLOTS; i++)
            perm_img[i] = i[POS_W-1:0];
        for (int i = 0; i <= PERM_SLOTS; i++)
            level_cnt[i] = '0;
        seq_started = 1'b0;
    endfunction

    // Apply one command to the model and return the answer it produces.
    function automatic t_answer enumerate_step(input t_kind kind,
                                               input logic [IDX_W-1:0] idx);
        t_answer          ans;
        int               n;
        int               c;
        int               hi;
        int               lo;
        logic [POS_W-1:0] tmp;
        ans.status     = ST_START;
        ans.first_pos  = '0;
        ans.second_pos = '0;
        ans.value      = '0;
        if (kind == KIND_READ) begin
            ans.status = ST_READ;
            if (int'(idx) < PERM_SLOTS)
                ans.value = perm_img[idx];
            return ans;
        end
        // first advance after re-arming loads the identity
        if (!seq_started) begin
            rearm_perm();
            seq_started = 1'b1;
            return ans;
        end
        n = (int'(count_reg) > PERM_SLOTS) ? PERM_SLOTS : int'(count_reg);
        for (int k = 2; k <= n; k++) begin
            c = int'(level_cnt[k]);
            if (c != k - 1) begin
                c++;
                level_cnt[k] = c[POS_W-1:0];
                hi = k - 1;
                lo = k - 2;
                // even levels past their second step swap with a moving partner
                if ((k % 2) == 0 && c > 2)
                    lo = k - 1 - c;
                tmp          = perm_img[hi];
                perm_img[hi] = perm_img[lo];
                perm_img[lo] = tmp;
                ans.status     = ST_SWAP;
                ans.first_pos  = hi[POS_W-1:0];
                ans.second_pos = lo[POS_W-1:0];
                return ans;
            end
            level_cnt[k] = '0;
        end
        // no level left to bump: sequence exhausted, re-arm
        seq_started = 1'b0;
        ans.status  = ST_EXHAUST;
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Command driver: changes inputs on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rst_done) begin
            if (start && !cmd_taken) begin
                // hold the pending command until busy drops
            end else if (cmd_backlog.size() != 0 &&
                         (no_gap || $urandom_range(99) >= 23)) begin
                start   <= 1'b1;
                i_kind  <= cmd_backlog[0].kind;
                i_index <= cmd_backlog[0].index;
            end else begin
                start   <= 1'b0;
                i_kind  <= 1'($urandom_range(1));
                i_index <= 4'($urandom_range(15));
            end
        end
        cmd_taken = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: samples on the rising edge, checks results, then logs the
    // command transfer of this edge into the model
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_answers.size() == 0) begin
                    note_mismatch($sformatf("result with nothing pending, status %0d",
                                            o_status));
                end else begin
                    exp_ans = pending_answers.pop_front();
                    if (o_status !== exp_ans.status)
                        note_mismatch($sformatf("status %0d, want %0d",
                                                o_status, exp_ans.status));
                    if (o_first_pos !== exp_ans.first_pos)
                        note_mismatch($sformatf("first_pos %0d, want %0d",
                                                o_first_pos, exp_ans.first_pos));
                    if (o_second_pos !== exp_ans.second_pos)
                        note_mismatch($sformatf("second_pos %0d, want %0d",
                                                o_second_pos, exp_ans.second_pos));
                    if (o_value !== exp_ans.value)
                        note_mismatch($sformatf("value %0d, want %0d",
                                                o_value, exp_ans.value));
                end
            end
            if (start && !busy) begin
                pending_answers.push_back(enumerate_step(t_kind'(i_kind), i_index));
                void'(cmd_backlog.pop_front());
                cmd_taken = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // APB helpers, driven on the falling edge
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only the item_count register exists; a write there re-arms
        if (addr == ADDR_ITEM_COUNT) begin
            count_reg = data[CFG_W-1:0];
            rearm_perm();
        end
    endtask

    task automatic apb_check_count();
        logic [APB_DW-1:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ITEM_COUNT;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[CFG_W-1:0] !== count_reg)
            note_mismatch($sformatf("item_count reads %0d, want %0d",
                                    rd[CFG_W-1:0], count_reg));
    endtask

    // wait until every command has transferred and every answer is back
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || pending_answers.size() != 0 || start)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic queue_cmd(input t_kind kind, input int idx);
        t_cmd c;
        c.kind  = kind;
        c.index = idx[IDX_W-1:0];
        cmd_backlog.push_back(c);
    endtask

    task automatic queue_advances(input int cnt);
        for (int i = 0; i < cnt; i++)
            queue_cmd(KIND_ADVANCE, $urandom_range(15));
    endtask

    task automatic set_count(input int n);
        logic [APB_DW-1:0] data;
        data = $urandom();
        data[CFG_W-1:0] = n[CFG_W-1:0];
        wait_drained();
        apb_write(ADDR_ITEM_COUNT, data);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int issued;
        int n;
        int pick;
        int seq_len;
        int reps;
        int phase;
        count_reg = ITEM_COUNT_RESET;
        rearm_perm();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        // directed part, reset count of 16
        queue_cmd(KIND_READ, 0);          // read before start sees identity
        queue_cmd(KIND_READ, 15);
        queue_advances(6);                // start, then swaps
        queue_cmd(KIND_READ, 0);
        queue_cmd(KIND_READ, 2);
        wait_drained();
        apb_check_count();
        apb_write(ADDR_UNMAPPED, 32'hFFFF_FFE3);   // must not re-arm
        queue_advances(2);
        queue_cmd(KIND_READ, 1);
        set_count(0);                     // zero and one: start then exhaust
        queue_advances(3);
        queue_cmd(KIND_READ, 5);
        set_count(1);
        queue_advances(2);
        set_count(31);                    // above maximum clamps to 16
        apb_check_count();
        queue_advances(3);
        queue_cmd(KIND_READ, 15);
        set_count(2);
        queue_advances(4);
        queue_cmd(KIND_READ, 15);         // beyond count keeps identity
        wait_drained();

        // random phases: mostly complete sequences on small counts
        issued = 0;
        phase  = 0;
        while (issued < ITEM_GOAL) begin
            pick = $urandom_range(99);
            if (pick < 60)
                n = $urandom_range(5, 2);
            else if (pick < 70)
                n = $urandom_range(1, 0);
            else if (pick < 90)
                n = $urandom_range(16, 6);
            else
                n = $urandom_range(31, 17);
            set_count(n);
            if ($urandom_range(3) == 0)
                apb_check_count();
            no_gap = (phase == 4 || phase == 5);
            if (n <= 4) begin
                // advances per full walk: start, n!-1 swaps, exhaustion
                seq_len = 1;
                for (int i = 2; i <= n; i++)
                    seq_len *= i;
                reps    = $urandom_range(3, 1);
                seq_len = (seq_len + 1) * reps + $urandom_range(2);
            end else begin
                seq_len = $urandom_range(120, 20);
            end
            // keep the back-to-back stretch long
            if (no_gap && seq_len < 150)
                seq_len = 150;
            for (int i = 0; i < seq_len; i++) begin
                if ($urandom_range(99) < 18) begin
                    queue_cmd(KIND_READ, $urandom_range(15));
                    issued++;
                end
                queue_cmd(KIND_ADVANCE, $urandom_range(15));
                issued++;
            end
            phase++;
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("[permutation_transposition_enumerator_core] OK");
        end else begin
            $display("[permutation_transposition_enumerator_core] ERROR");
        end
        $finish;
    end

endmodule
